@@ sv/tksd_pkg.sv @@
package tksd_pkg;

  // Parser states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ESC,
    ST_CSI,
    ST_CSI_DIGIT,
    ST_SS3,
    ST_PREFIX
  } parse_state_t;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Register indexes (byte address bit 2)
  localparam logic REG_SCAN_CODE_MODE = 1'b0;
  localparam logic REG_TIMEOUT_TICKS  = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  // Byte codes
  localparam logic [7:0] ESC_CODE     = 8'd27;
  localparam logic [7:0] NUL_CODE     = 8'd0;
  localparam logic [7:0] EXT_PREFIX   = 8'd224;
  localparam logic [7:0] CHR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHR_O        = 8'h4F;
  localparam logic [7:0] CHR_TILDE    = 8'h7E;
  localparam logic [7:0] CHR_ZERO     = 8'h30;
  localparam logic [7:0] CHR_NINE     = 8'h39;
  localparam logic [7:0] CHR_UPPER_A  = 8'h41;
  localparam logic [7:0] CHR_UPPER_B  = 8'h42;
  localparam logic [7:0] CHR_UPPER_C  = 8'h43;
  localparam logic [7:0] CHR_UPPER_D  = 8'h44;
  localparam logic [7:0] CHR_UPPER_F  = 8'h46;
  localparam logic [7:0] CHR_UPPER_H  = 8'h48;

  // Key numbers
  localparam logic [3:0] NAV_UP        = 4'd0;
  localparam logic [3:0] NAV_DOWN      = 4'd1;
  localparam logic [3:0] NAV_LEFT      = 4'd2;
  localparam logic [3:0] NAV_RIGHT     = 4'd3;
  localparam logic [3:0] NAV_HOME      = 4'd4;
  localparam logic [3:0] NAV_END       = 4'd5;
  localparam logic [3:0] NAV_PAGE_UP   = 4'd6;
  localparam logic [3:0] NAV_PAGE_DOWN = 4'd7;
  localparam logic [3:0] NAV_INS       = 4'd8;
  localparam logic [3:0] NAV_DEL       = 4'd9;
  localparam logic [3:0] NAV_LAST      = NAV_DEL;

  // Key lookup result: hit flag and key number
  typedef struct packed {
    logic       hit;
    logic [3:0] key;
  } key_lookup_t;

  // Configuration seen by the decoder
  typedef struct packed {
    logic        scan_code_mode;
    logic [15:0] timeout_ticks;
    logic        mode_wr;
  } cfg_t;

  // One decoded result
  typedef struct packed {
    logic       emit;
    logic       is_special;
    logic [7:0] key_value;
  } result_t;

  function automatic key_lookup_t scan_key(input logic [7:0] b);
    key_lookup_t r;
    r.hit = 1'b1;
    unique case (b)
      8'd72:   r.key = NAV_UP;
      8'd80:   r.key = NAV_DOWN;
      8'd75:   r.key = NAV_LEFT;
      8'd77:   r.key = NAV_RIGHT;
      8'd71:   r.key = NAV_HOME;
      8'd79:   r.key = NAV_END;
      8'd73:   r.key = NAV_PAGE_UP;
      8'd81:   r.key = NAV_PAGE_DOWN;
      8'd82:   r.key = NAV_INS;
      8'd83:   r.key = NAV_DEL;
      default: begin
        r.hit = 1'b0;
        r.key = NAV_UP;
      end
    endcase
    return r;
  endfunction

  function automatic key_lookup_t csi_key(input logic [7:0] b);
    key_lookup_t r;
    r.hit = 1'b1;
    unique case (b)
      CHR_UPPER_A: r.key = NAV_UP;
      CHR_UPPER_B: r.key = NAV_DOWN;
      CHR_UPPER_C: r.key = NAV_RIGHT;
      CHR_UPPER_D: r.key = NAV_LEFT;
      CHR_UPPER_H: r.key = NAV_HOME;
      CHR_UPPER_F: r.key = NAV_END;
      default: begin
        r.hit = 1'b0;
        r.key = NAV_UP;
      end
    endcase
    return r;
  endfunction

  // ESC [ digit ~ : digits 1..8 only
  function automatic key_lookup_t digit_key(input logic [3:0] d);
    key_lookup_t r;
    r.hit = 1'b1;
    unique case (d)
      4'd1:    r.key = NAV_HOME;
      4'd2:    r.key = NAV_INS;
      4'd3:    r.key = NAV_DEL;
      4'd4:    r.key = NAV_END;
      4'd5:    r.key = NAV_PAGE_UP;
      4'd6:    r.key = NAV_PAGE_DOWN;
      4'd7:    r.key = NAV_HOME;
      4'd8:    r.key = NAV_END;
      default: begin
        r.hit = 1'b0;
        r.key = NAV_UP;
      end
    endcase
    return r;
  endfunction

endpackage

@@ sv/tksd_if.sv @@
interface tksd_key_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface tksd_event_if;
  logic       valid;
  logic       ready;
  logic       is_special;
  logic [7:0] key_value;

  modport source (output valid, output is_special, output key_value, input ready);
  modport sink (input valid, input is_special, input key_value, output ready);
endinterface

@@ sv/tksd_regs.sv @@
module tksd_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output tksd_pkg::cfg_t   cfg
);
  import tksd_pkg::*;

  logic        scan_code_mode;
  logic [15:0] timeout_ticks;
  logic        wr;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_code_mode <= 1'b0;
      timeout_ticks  <= TIMEOUT_RESET;
    end else if (wr) begin
      if (reg_sel == REG_SCAN_CODE_MODE) begin
        scan_code_mode <= pwdata[0];
      end else begin
        timeout_ticks <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_SCAN_CODE_MODE) begin
      prdata = {31'd0, scan_code_mode};
    end else begin
      prdata = {16'd0, timeout_ticks};
    end
  end

  assign cfg.scan_code_mode = scan_code_mode;
  assign cfg.timeout_ticks  = timeout_ticks;
  assign cfg.mode_wr        = wr && (reg_sel == REG_SCAN_CODE_MODE);

endmodule

@@ sv/tksd_decode.sv @@
module tksd_decode (
  input  logic              clk,
  input  logic              rst,
  input  tksd_pkg::cfg_t    cfg,
  input  logic              step,
  input  logic              opcode,
  input  logic [7:0]        rx_byte,
  output tksd_pkg::result_t res
);
  import tksd_pkg::*;

  parse_state_t state, state_next;
  logic [3:0]   held_digit, held_digit_next;
  logic [15:0]  idle_ticks, idle_ticks_next;

  always_ff @(posedge clk) begin
    if (rst || cfg.mode_wr) begin
      state      <= ST_IDLE;
      held_digit <= 4'd0;
      idle_ticks <= 16'd0;
    end else if (step) begin
      state      <= state_next;
      held_digit <= held_digit_next;
      idle_ticks <= idle_ticks_next;
    end
  end

  always_comb begin
    logic [15:0] ticks_inc;
    logic        abandon;
    key_lookup_t scan_hit;
    key_lookup_t csi_hit;
    key_lookup_t dig_hit;

    ticks_inc       = idle_ticks + 16'd1;
    abandon         = 1'b0;
    scan_hit        = scan_key(rx_byte);
    csi_hit         = csi_key(rx_byte);
    dig_hit         = digit_key(held_digit);
    state_next      = state;
    held_digit_next = held_digit;
    idle_ticks_next = idle_ticks;
    res             = '0;

    if (opcode == OP_TICK) begin
      if (!cfg.scan_code_mode && state != ST_IDLE && state != ST_PREFIX) begin
        idle_ticks_next = ticks_inc;
        if (ticks_inc >= cfg.timeout_ticks) begin
          abandon = 1'b1;
        end
      end
    end else if (cfg.scan_code_mode) begin
      state_next      = ST_IDLE;
      held_digit_next = 4'd0;
      idle_ticks_next = 16'd0;
      if (state == ST_PREFIX) begin
        res.emit       = scan_hit.hit;
        res.is_special = 1'b1;
        res.key_value  = {4'd0, scan_hit.key};
      end else if (rx_byte == NUL_CODE || rx_byte == EXT_PREFIX) begin
        state_next = ST_PREFIX;
      end else begin
        res.emit      = 1'b1;
        res.key_value = rx_byte;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (rx_byte == ESC_CODE) begin
            state_next      = ST_ESC;
            idle_ticks_next = 16'd0;
          end else if (rx_byte != NUL_CODE) begin
            res.emit      = 1'b1;
            res.key_value = rx_byte;
          end
        end
        ST_ESC: begin
          idle_ticks_next = 16'd0;
          if (rx_byte == CHR_LBRACKET) begin
            state_next = ST_CSI;
          end else if (rx_byte == CHR_O) begin
            state_next = ST_SS3;
          end else begin
            abandon = 1'b1;
          end
        end
        ST_CSI: begin
          if (rx_byte >= CHR_ZERO && rx_byte <= CHR_NINE) begin
            held_digit_next = rx_byte[3:0];
            state_next      = ST_CSI_DIGIT;
            idle_ticks_next = 16'd0;
          end else if (csi_hit.hit) begin
            state_next      = ST_IDLE;
            held_digit_next = 4'd0;
            idle_ticks_next = 16'd0;
            res.emit        = 1'b1;
            res.is_special  = 1'b1;
            res.key_value   = {4'd0, csi_hit.key};
          end else begin
            abandon = 1'b1;
          end
        end
        ST_CSI_DIGIT: begin
          if (rx_byte == CHR_TILDE && dig_hit.hit) begin
            state_next      = ST_IDLE;
            held_digit_next = 4'd0;
            idle_ticks_next = 16'd0;
            res.emit        = 1'b1;
            res.is_special  = 1'b1;
            res.key_value   = {4'd0, dig_hit.key};
          end else begin
            abandon = 1'b1;
          end
        end
        ST_SS3: begin
          if (rx_byte == CHR_UPPER_H || rx_byte == CHR_UPPER_F) begin
            state_next      = ST_IDLE;
            held_digit_next = 4'd0;
            idle_ticks_next = 16'd0;
            res.emit        = 1'b1;
            res.is_special  = 1'b1;
            res.key_value   = {4'd0, (rx_byte == CHR_UPPER_H) ? NAV_HOME : NAV_END};
          end else begin
            abandon = 1'b1;
          end
        end
        default: begin
          abandon = 1'b1;
        end
      endcase
    end

    // Drop the sequence and report a lone ESC
    if (abandon) begin
      state_next      = ST_IDLE;
      held_digit_next = 4'd0;
      idle_ticks_next = 16'd0;
      res.emit        = 1'b1;
      res.is_special  = 1'b0;
      res.key_value   = ESC_CODE;
    end
  end

  a_mode_wr_clears: assert property (@(posedge clk) disable iff (rst)
    cfg.mode_wr |=> (state == ST_IDLE && idle_ticks == 16'd0))
    else $error("mode write did not clear the parser");

  a_scan_states: assert property (@(posedge clk) disable iff (rst)
    cfg.scan_code_mode |-> (state == ST_IDLE || state == ST_PREFIX))
    else $error("escape state reached in scan-code mode");

  a_held_digit_range: assert property (@(posedge clk) disable iff (rst)
    held_digit <= 4'd9)
    else $error("held digit out of range");

endmodule

@@ sv/terminal_key_sequence_decoder.sv @@
// Path: an accepted transaction is held in the input register and decoded into the
//   result register when the parser steps; its key event is valid from that register.
// Throughput: one byte or tick per cycle; an item waits in the input register only
//   while the result register holds an event that the sink has not taken.
// Reset (rst, synchronous): both stages empty, parser idle, ANSI mode, timeout 100.
module terminal_key_sequence_decoder (
  input  logic         clk,
  input  logic         rst,
  tksd_key_if.sink     keys,
  tksd_event_if.source events,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import tksd_pkg::*;

  cfg_t    cfg;
  result_t res;

  // Input register
  logic       s1_valid;
  logic       s1_opcode;
  logic [7:0] s1_byte;

  // Result register
  logic       out_valid;
  logic       out_special;
  logic [7:0] out_value;

  logic step;
  logic take;

  // Configuration registers behind the APB port
  tksd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held item through the parser when the result register is free
  // or is being emptied in this cycle.
  assign step       = s1_valid && (!out_valid || events.ready);
  assign keys.ready = !s1_valid || step;
  assign take       = keys.valid && keys.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take || (s1_valid && !step);
    end
  end

  // Capture the payload on each accepted transaction; hold it otherwise.
  always_ff @(posedge clk) begin
    if (take) begin
      s1_opcode <= keys.opcode;
      s1_byte   <= keys.rx_byte;
    end
  end

  // Parser state machine and key tables
  tksd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (step),
    .opcode  (s1_opcode),
    .rx_byte (s1_byte),
    .res     (res)
  );

  // Result register: load on a step, drop once the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res.emit;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_special <= res.is_special;
      out_value   <= res.key_value;
    end
  end

  assign events.valid      = out_valid;
  assign events.is_special = out_special;
  assign events.key_value  = out_value;

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !step) |=> (s1_valid && $stable(s1_byte) && $stable(s1_opcode)))
    else $error("input register lost an unprocessed item");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !events.ready) |=>
      (out_valid && $stable(out_special) && $stable(out_value)))
    else $error("result register changed while the sink stalled");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_special) |-> (out_value <= {4'd0, NAV_LAST}))
    else $error("navigation key number out of range");

endmodule
